// File: sv/mjdcal_pkg.sv
// ----------------------------------------------------------------------------
// mjdcal_pkg
// Shared types and constants for the MJD to calendar date converter: request
// and response payloads, calendar offsets and constant-divisor reciprocals.
// ----------------------------------------------------------------------------
package mjdcal_pkg;

    typedef struct packed {
        logic signed [22:0] mjd_day;
        logic        [31:0] day_fraction;
    } mjd_req_t;

    typedef struct packed {
        logic signed [14:0] year;
        logic        [3:0]  month;
        logic        [4:0]  day;
        logic        [4:0]  hour;
        logic        [5:0]  minute;
        logic        [25:0] second;
    } mjd_rsp_t;

    // time of day and calendar field limits
    localparam int unsigned HOURS_PER_DAY   = 24;
    localparam int unsigned MINS_PER_HOUR   = 60;
    localparam int unsigned SECS_PER_MIN    = 60;
    localparam int unsigned MONTHS_PER_YEAR = 12;
    localparam int unsigned DAYS_MAX        = 31;

    // day number and calendar switch
    localparam logic signed [23:0] DAYNUM_OFFSET  = 24'sd2400001;
    localparam logic signed [23:0] GREG_START     = 24'sd2299161;
    localparam logic signed [27:0] CENTURY_ORIGIN = 28'sd7468865;
    localparam logic        [23:0] JULIAN_BIAS    = 24'd1524;
    localparam logic        [23:0] GREG_BIAS      = 24'd1525;

    // century correction: floor(n / 146097), n < 2**25
    localparam logic [26:0] CENTURY_DIV   = 27'd146097;
    localparam logic [32:0] CENTURY_RECIP = 33'd229;
    localparam int unsigned CENTURY_SHIFT = 25;

    // year count: floor((20c - 2442) / 7305), biased to stay non-negative
    localparam logic [27:0] YEAR_DIV      = 28'd7305;
    localparam logic [43:0] YEAR_RECIP    = 44'd36746;
    localparam int unsigned YEAR_SHIFT    = 28;
    localparam logic [27:0] YEAR_NUM_BIAS = 28'd35857803;
    localparam logic [15:0] YEAR_Q_BIAS   = 16'd4909;
    localparam logic [23:0] DAYS_PER_YEAR = 24'd365;
    localparam logic [15:0] YEAR_EPOCH    = 16'd4715;

    // month count: floor(10000 * ce / 306001)
    localparam logic [20:0] MONTH_RECIP   = 21'd2141;
    localparam int unsigned MONTH_SHIFT   = 16;
    localparam logic [22:0] MONTH_SCALE   = 23'd10000;
    localparam logic [22:0] MONTH_DIV     = 23'd306001;

    // floor(30.6001 * f)
    function automatic logic [8:0] month_start(input logic [3:0] f);
        logic [8:0] res;
        case (f)
            4'd0:    res = 9'd0;
            4'd1:    res = 9'd30;
            4'd2:    res = 9'd61;
            4'd3:    res = 9'd91;
            4'd4:    res = 9'd122;
            4'd5:    res = 9'd153;
            4'd6:    res = 9'd183;
            4'd7:    res = 9'd214;
            4'd8:    res = 9'd244;
            4'd9:    res = 9'd275;
            4'd10:   res = 9'd306;
            4'd11:   res = 9'd336;
            4'd12:   res = 9'd367;
            4'd13:   res = 9'd397;
            4'd14:   res = 9'd428;
            4'd15:   res = 9'd459;
            default: res = 9'd0;
        endcase
        return res;
    endfunction

endpackage

// File: sv/mjd_to_calendar_date.sv
// ----------------------------------------------------------------------------
// mjd_to_calendar_date
// Converts a Modified Julian Date with a Q0.32 day fraction into calendar
// year, month and day plus hour, minute and Q6.20 seconds.
//
// A request enters on req_valid/req_ready and carries mjd_day and
// day_fraction; the response leaves on rsp_valid/rsp_ready. Days before the
// Gregorian switch use the Julian calendar, later days the Gregorian one.
// The work runs through a fourteen-stage pipeline of constant-divisor steps
// (reciprocal multiply, remainder, correction); the time of day goes through
// three multiply-by-constant stages alongside it.
// Throughput: one request per cycle, set by one pipeline stage, while
// rsp_ready does not stall the output.
// Every stage has its own valid bit and loads when it is empty or the stage
// after it moves, so bubbles close up while rsp_ready is low and requests
// keep entering until the pipeline is full; nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and req_ready is high
// after reset.
// ----------------------------------------------------------------------------
module mjd_to_calendar_date
    import mjdcal_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_ready,
    input  mjd_req_t req_data,
    output logic     rsp_valid,
    input  logic     rsp_ready,
    output mjd_rsp_t rsp_data
);

    localparam int NUM_STAGES = 14;
    localparam int LAST       = NUM_STAGES - 1;

    typedef struct packed {
        logic signed [23:0] a;
        logic               greg;
        logic        [24:0] n1;
        logic        [32:0] p1;
        logic        [7:0]  q1;
        logic        [18:0] r1;
        logic        [7:0]  corr;
        logic signed [23:0] c;
        logic        [27:0] n2;
        logic        [43:0] p2;
        logic        [15:0] q2;
        logic        [13:0] r2;
        logic signed [15:0] d;
        logic        [8:0]  ce;
        logic        [3:0]  q4;
        logic        [19:0] r4;
        logic        [3:0]  f;
        logic        [37:0] tm;
        logic        [4:0]  hour;
        logic        [5:0]  minute;
        logic        [25:0] second;
        logic signed [14:0] year;
        logic        [3:0]  month;
        logic        [4:0]  day;
    } pipe_t;

    pipe_t                 pipe_reg  [NUM_STAGES];
    pipe_t                 pipe_next [NUM_STAGES];
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] stage_en;

    logic signed [23:0] a_s0;
    logic signed [27:0] n1_wide;
    logic        [26:0] r1_wide;
    logic        [23:0] c_greg;
    logic        [27:0] r2_wide;
    logic        [15:0] d_wide;
    logic        [23:0] ce_wide;
    logic        [20:0] p4_wide;
    logic        [22:0] r4_wide;
    logic        [15:0] year_wide;
    logic        [3:0]  month_s13;

    // stall chain
    always_comb
    begin
        stage_en[LAST] = !valid_reg[LAST] || rsp_ready;
        for (int k = LAST - 1; k >= 0; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    assign req_ready = stage_en[0];

    always_comb
    begin
        pipe_next[0] = pipe_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            pipe_next[k] = pipe_reg[k-1];
        end

        // stage 0: day number, calendar choice, century numerator, hours
        a_s0    = $signed({req_data.mjd_day[22], req_data.mjd_day}) + DAYNUM_OFFSET;
        n1_wide = $signed({a_s0[23], a_s0, 3'b000} >>> 1) - CENTURY_ORIGIN;
        pipe_next[0].a    = a_s0;
        pipe_next[0].greg = (a_s0 >= GREG_START);
        pipe_next[0].n1   = (a_s0 >= GREG_START) ? n1_wide[24:0] : '0;
        pipe_next[0].tm   = {6'd0, req_data.day_fraction} * 38'(HOURS_PER_DAY);

        // stage 1: century reciprocal, minutes
        pipe_next[1].p1   = {8'd0, pipe_reg[0].n1} * CENTURY_RECIP;
        pipe_next[1].hour = pipe_reg[0].tm[36:32];
        pipe_next[1].tm   = {6'd0, pipe_reg[0].tm[31:0]} * 38'(MINS_PER_HOUR);

        // stage 2: century remainder, seconds
        pipe_next[2].q1     = pipe_reg[1].p1[CENTURY_SHIFT +: 8];
        r1_wide             = {2'd0, pipe_reg[1].n1}
                              - {19'd0, pipe_reg[1].p1[CENTURY_SHIFT +: 8]} * CENTURY_DIV;
        pipe_next[2].r1     = r1_wide[18:0];
        pipe_next[2].minute = pipe_reg[1].tm[37:32];
        pipe_next[2].tm     = {6'd0, pipe_reg[1].tm[31:0]} * 38'(SECS_PER_MIN);

        // stage 3: century correction
        pipe_next[3].corr   = pipe_reg[2].q1
                              + {7'd0, (pipe_reg[2].r1 >= CENTURY_DIV[18:0])};
        pipe_next[3].second = pipe_reg[2].tm[37:12];

        // stage 4: shifted day count
        c_greg = pipe_reg[3].a + {16'd0, pipe_reg[3].corr}
                 - {18'd0, pipe_reg[3].corr[7:2]} + GREG_BIAS;
        pipe_next[4].c = pipe_reg[3].greg ? $signed(c_greg)
                                          : $signed(pipe_reg[3].a + JULIAN_BIAS);

        // stage 5: biased year numerator
        pipe_next[5].n2 = {{4{pipe_reg[4].c[23]}}, pipe_reg[4].c} * 28'd20 + YEAR_NUM_BIAS;

        // stage 6: year reciprocal
        pipe_next[6].p2 = {16'd0, pipe_reg[5].n2} * YEAR_RECIP;

        // stage 7: year remainder
        pipe_next[7].q2 = pipe_reg[6].p2[YEAR_SHIFT +: 16];
        r2_wide         = pipe_reg[6].n2
                          - {12'd0, pipe_reg[6].p2[YEAR_SHIFT +: 16]} * YEAR_DIV;
        pipe_next[7].r2 = r2_wide[13:0];

        // stage 8: year count
        d_wide          = pipe_reg[7].q2 + {15'd0, (pipe_reg[7].r2 >= YEAR_DIV[13:0])}
                          - YEAR_Q_BIAS;
        pipe_next[8].d  = $signed(d_wide);

        // stage 9: day within the shifted year
        ce_wide = pipe_reg[8].c
                  - {{8{pipe_reg[8].d[15]}}, pipe_reg[8].d} * DAYS_PER_YEAR
                  - {{10{pipe_reg[8].d[15]}}, pipe_reg[8].d[15:2]};
        pipe_next[9].ce = ce_wide[8:0];

        // stage 10: month reciprocal
        p4_wide          = {12'd0, pipe_reg[9].ce} * MONTH_RECIP;
        pipe_next[10].q4 = p4_wide[MONTH_SHIFT +: 4];

        // stage 11: month remainder
        r4_wide = {14'd0, pipe_reg[10].ce} * MONTH_SCALE
                  - {19'd0, pipe_reg[10].q4} * MONTH_DIV;
        pipe_next[11].r4 = r4_wide[19:0];

        // stage 12: month count
        pipe_next[12].f = pipe_reg[11].q4 + {3'd0, (pipe_reg[11].r4 >= MONTH_DIV[19:0])};

        // stage 13: calendar fields
        month_s13 = (pipe_reg[12].f < 4'd14) ? pipe_reg[12].f - 4'd1
                                             : pipe_reg[12].f - 4'(MONTHS_PER_YEAR + 1);
        year_wide = pipe_reg[12].d - YEAR_EPOCH - {15'd0, (month_s13 >= 4'd3)};
        pipe_next[13].month = month_s13;
        pipe_next[13].year  = $signed(year_wide[14:0]);
        pipe_next[13].day   = 5'(pipe_reg[12].ce - month_start(pipe_reg[12].f));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= req_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NUM_STAGES; k++)
        begin
            if (stage_en[k])
            begin
                pipe_reg[k] <= pipe_next[k];
            end
        end
    end

    assign rsp_valid       = valid_reg[LAST];
    assign rsp_data.year   = pipe_reg[LAST].year;
    assign rsp_data.month  = pipe_reg[LAST].month;
    assign rsp_data.day    = pipe_reg[LAST].day;
    assign rsp_data.hour   = pipe_reg[LAST].hour;
    assign rsp_data.minute = pipe_reg[LAST].minute;
    assign rsp_data.second = pipe_reg[LAST].second;

endmodule

// File: sv/mjd_to_calendar_date_chk.sv
// ----------------------------------------------------------------------------
// mjd_to_calendar_date_chk
// Port-level checks for the MJD to calendar date converter, bound to the
// top level.
// ----------------------------------------------------------------------------
module mjd_to_calendar_date_chk
    import mjdcal_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_ready,
    input mjd_req_t req_data,
    input logic     rsp_valid,
    input logic     rsp_ready,
    input mjd_rsp_t rsp_data
);

    // stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("response changed while stalled");

    // empty output stage never blocks a request
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request blocked with empty output");

    // a taken response frees the whole pipeline
    a_ready_drain: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_ready |-> req_ready)
        else $error("request blocked while response taken");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp_data.month >= 4'd1 && rsp_data.month <= 4'(MONTHS_PER_YEAR)
                   && rsp_data.day >= 5'd1 && rsp_data.day <= 5'(DAYS_MAX)
                   && rsp_data.hour < 5'(HOURS_PER_DAY)
                   && rsp_data.minute < 6'(MINS_PER_HOUR))
        else $error("response field out of range");

endmodule

bind mjd_to_calendar_date mjd_to_calendar_date_chk u_chk (.*);

// File: tb/tb_mjd_to_calendar_date.sv
// ----------------------------------------------------------------------------
// tb_mjd_to_calendar_date
// Self-checking testbench for the MJD to calendar date converter. Requests
// are sent on the req channel and every response is checked, field by field,
// against a calendar predictor held in the bench. The run covers a directed
// set of corner dates and times, random traffic under three idle patterns on
// the request and response sides, and a long response stall that fills the
// pipeline.
// ----------------------------------------------------------------------------
module tb_mjd_to_calendar_date;
    import mjdcal_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_TAIL  = 30;
    localparam int STALL_LEN   = 400;

    logic     clk       = 1'b0;
    logic     rst_n     = 1'b0;
    logic     req_valid = 1'b0;
    logic     req_ready;
    mjd_req_t req_data  = '0;
    logic     rsp_valid;
    logic     rsp_ready = 1'b0;
    mjd_rsp_t rsp_data;

    mjd_rsp_t calendar_due[$];
    mjd_rsp_t want;
    int       errors       = 0;
    int       send_idle    = 0;
    int       recv_idle    = 0;
    int       hold_request = 0;
    int       hold_cnt     = 0;
    int       cycle_cnt    = 0;

    mjd_to_calendar_date u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic longint floor_quot(input longint n, input longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic mjd_rsp_t predict_calendar(input mjd_req_t r);
        longint          a, c, d, e, f, dom, mon, yr, corr;
        longint unsigned t;
        mjd_rsp_t        p;
        a = longint'($signed(r.mjd_day)) + longint'(DAYNUM_OFFSET);
        if (a < longint'(GREG_START))
        begin
            c = a + 1524;
        end
        else
        begin
            // gregorian century correction
            corr = floor_quot(4 * a - 7468865, 146097);
            c = a + corr - floor_quot(corr, 4) + 1525;
        end
        d   = floor_quot(20 * c - 2442, 7305);
        e   = 365 * d + floor_quot(d, 4);
        f   = floor_quot(10000 * (c - e), 306001);
        dom = c - e - floor_quot(306001 * f, 10000);
        mon = f - 1 - 12 * floor_quot(f, 14);
        yr  = d - 4715 - floor_quot(7 + mon, 10);
        p.year  = yr[14:0];
        p.month = mon[3:0];
        p.day   = dom[4:0];
        t = longint'(r.day_fraction) * 24;
        p.hour = t[36:32];
        t = longint'(t[31:0]) * 60;
        p.minute = t[37:32];
        t = longint'(t[31:0]) * 60;
        p.second = t[37:12];
        return p;
    endfunction

    function automatic mjd_req_t make_request(input int mjd, input logic [31:0] frac);
        mjd_req_t r;
        r.mjd_day      = mjd[22:0];
        r.day_fraction = frac;
        return r;
    endfunction

    function automatic mjd_req_t rand_request();
        int          mjd;
        longint      base;
        logic [31:0] frac;
        case ($urandom_range(9))
            0, 1:    mjd = int'($urandom());
            2:       mjd = -100840 + int'($urandom_range(24)) - 12;
            default: mjd = int'($urandom_range(5373484)) - 2400000;
        endcase
        case ($urandom_range(9))
            0:       frac = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
            1:
            begin
                // just either side of an hour boundary
                base = (longint'($urandom_range(1, 23)) << 32) / 24;
                frac = 32'(base + longint'($urandom_range(4)) - 2);
            end
            2:
            begin
                // just either side of a minute boundary
                base = (longint'($urandom_range(1, 1439)) << 32) / 1440;
                frac = 32'(base + longint'($urandom_range(4)) - 2);
            end
            default: frac = $urandom();
        endcase
        return make_request(mjd, frac);
    endfunction

    task automatic report_field(input string name, input longint exp_v, input longint act_v);
        if (exp_v != act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
        end
    endtask

    // response checker
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (calendar_due.size() == 0)
            begin
                errors++;
                $display("%0t: response with no request outstanding, expected none, got %p",
                         $time, rsp_data);
            end
            else
            begin
                want = calendar_due.pop_front();
                report_field("year", $signed(want.year), $signed(rsp_data.year));
                report_field("month", want.month, rsp_data.month);
                report_field("day", want.day, rsp_data.day);
                report_field("hour", want.hour, rsp_data.hour);
                report_field("minute", want.minute, rsp_data.minute);
                report_field("second", want.second, rsp_data.second);
            end
        end
    end

    // response side ready, with an optional long hold-off
    always @(posedge clk)
    begin
        if (hold_request != 0)
        begin
            hold_cnt     = hold_request;
            hold_request = 0;
        end
        if (hold_cnt != 0)
        begin
            hold_cnt  = hold_cnt - 1;
            rsp_ready <= 1'b0;
        end
        else
        begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(input mjd_req_t r);
        while ($urandom_range(99) < send_idle)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        calendar_due.push_back(predict_calendar(r));
    endtask

    task automatic wait_drained();
        req_valid <= 1'b0;
        while (calendar_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_TAIL) @(posedge clk);
    endtask

    task automatic send_random(input int count);
        for (int i = 0; i < count; i++)
            send_request(rand_request());
        wait_drained();
    endtask

    task automatic test_directed_corners();
        int          mjd_list[$];
        logic [31:0] frac_list[$];
        mjd_list  = '{-4194304, 4194303, -2400000, 2973484, -2400001, -100841, -100840,
                      -100839, 0, -1, 51603, 51544, 15078, 15077, -678942, -679006,
                      60000, 1000000, -3000000, 51604, 2973483, -2399999};
        frac_list = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h0000_0001, 32'hAAAA_AAAB, 32'h5555_5555, 32'h0AAA_AAAA,
                      32'h0AAA_AAAB, 32'hFFFF_FFFF, 32'h4000_0000, 32'h0000_0000,
                      32'hC000_0000, 32'h002D_82D8, 32'h002D_82D9, 32'h0000_0001,
                      32'h1234_5678, 32'hFFFF_F000, 32'h0000_1000, 32'hEDCB_A987,
                      32'hF555_5555, 32'h0000_0FFF};
        send_idle = 0;
        recv_idle = 0;
        foreach (mjd_list[i])
            send_request(make_request(mjd_list[i], frac_list[i]));
        wait_drained();
    endtask

    task automatic test_sparse_requests();
        send_idle = 23;
        recv_idle = 88;
        send_random(500);
    endtask

    task automatic test_sparse_responses();
        send_idle = 88;
        recv_idle = 23;
        send_random(500);
    endtask

    task automatic test_full_rate();
        send_idle = 0;
        recv_idle = 0;
        send_random(500);
    endtask

    task automatic test_output_stall();
        send_idle    = 0;
        recv_idle    = 0;
        hold_request = STALL_LEN;
        send_random(60);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_corners();
        test_sparse_requests();
        test_sparse_responses();
        test_full_rate();
        test_output_stall();
        if (errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
